### hw/rtl/i2c_eeprom_byte_access_master_top_assert.svh
// Assertion macros for the serial EEPROM byte access master.
// Used by the top level; no other dependencies.
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_TOP_ASSERT_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication checked on every clock edge outside reset
`define I2CEE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define I2CEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define I2CEE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define I2CEE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### hw/rtl/i2cee_pkg.sv
// Shared types and constants of the serial EEPROM byte access master.
// No dependencies; imported by i2cee_core and the top level.
package i2cee_pkg;

	// Default for the address width parameter
	localparam int ADDR_BITS_DEF = 16;

	// Command codes
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LARGE_ADDR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_WAIT  = 2'd2;
	localparam int CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic        RST_LARGE_ADDR  = 1'b0;
	localparam logic [7:0]  RST_ACK_TIMEOUT = 8'd250;
	localparam logic [15:0] RST_WRITE_WAIT  = 16'd700;

	// Control bytes
	localparam logic [7:0] CTRL_WR = 8'hA0;
	localparam logic [7:0] CTRL_RD = 8'hA1;

	// Stream widths
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 16;

	typedef struct packed {
		logic        large_addressing;
		logic [7:0]  ack_timeout;
		logic [15:0] write_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic        sda_in;
	} item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} result_t;

endpackage

### hw/rtl/i2c_eeprom_byte_access_master_top.sv
// Top level of the serial EEPROM byte access master: stream ports, input
// register, result register and configuration. Depends on i2cee_pkg, i2cee_core
// and i2c_eeprom_byte_access_master_top_assert.svh.

// Each input item is one bus phase tick and yields exactly one result item
// with the SCL/SDA drive levels and status for that tick. With the result side
// ready one item is taken per clock, and a result is presented once its item
// has passed the input register and then the phase step into the result
// register. A result that waits holds back the input once one more item sits
// in the input register.
// Commands (1 read, 2 write) are taken only when the sequencer is idle.
// Configuration is written through cfg_wen/cfg_idx/cfg_data while idle;
// index 0 large addressing, 1 acknowledge timeout, 2 write-cycle wait ticks.
`include "i2c_eeprom_byte_access_master_top_assert.svh"

module i2c_eeprom_byte_access_master_top #(
	parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [i2cee_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [i2cee_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// command[1:0], address[17:2], write_data[25:18], sda_in[26], zero pad
	input  logic [i2cee_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// scl[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
	// read_data[12:5], ack_error[13], zero pad
	output logic [i2cee_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import i2cee_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t core_res;
	logic    adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.large_addressing <= RST_LARGE_ADDR;
			cfg_q.ack_timeout      <= RST_ACK_TIMEOUT;
			cfg_q.write_wait_ticks <= RST_WRITE_WAIT;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_LARGE_ADDR:  cfg_q.large_addressing <= cfg_data[0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout      <= cfg_data[7:0];
				CFG_WRITE_WAIT:  cfg_q.write_wait_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.command    <= s_axis_tdata[1:0];
			item_s1.address    <= s_axis_tdata[17:2];
			item_s1.write_data <= s_axis_tdata[25:18];
			item_s1.sda_in     <= s_axis_tdata[26];
		end
	end

	i2cee_core #(
		.ADDR_BITS(ADDR_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(adv),
		.cfg    (cfg_q),
		.item   (item_s1),
		.res    (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= core_res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2.ack_error, res_s2.read_data, res_s2.done_res,
		res_s2.busy_res, res_s2.sda_drive, res_s2.sda_out, res_s2.scl};

	// Checks
	`I2CEE_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_axis_tready,
		valid_s1 && valid_s2 && !m_axis_tready, "input stalled without a held result")
	`I2CEE_ASSERT_NEXT(a_step_result, clk, arst_n, adv, m_axis_tvalid,
		"stepped item produced no result")
	`I2CEE_ASSERT_IMPL(a_done_busy, clk, arst_n, m_axis_tvalid && res_s2.done_res,
		res_s2.busy_res, "done reported outside a transaction")
	`I2CEE_ASSERT_IMPL(a_release_high, clk, arst_n, m_axis_tvalid && !res_s2.sda_drive,
		res_s2.sda_out, "released SDA not reported high")

endmodule

### hw/rtl/i2cee_core.sv
// Bus phase sequencer: holds the transfer state and computes one tick.
// Depends on i2cee_pkg.
module i2cee_core #(
	parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  i2cee_pkg::cfg_t    cfg,
	input  i2cee_pkg::item_t   item,
	output i2cee_pkg::result_t res
);
	import i2cee_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST2, PH_ST3, PH_RS0, PH_RS1, PH_TXL, PH_TXH, PH_AKL, PH_AKH,
		PH_RXL, PH_RXH, PH_NKL, PH_NKH, PH_SP1, PH_SP2, PH_SP3, PH_WAIT
	} phase_t;

	typedef enum logic [1:0] {EL_SEND, EL_RESTART, EL_READ, EL_STOP} elem_t;

	phase_t                 phase_q, phase_d;
	logic [2:0]             bit_count_q, bit_count_d;
	logic [7:0]             shift_byte_q, shift_byte_d;
	logic [2:0]             byte_step_q, byte_step_d;
	logic [ADDR_BITS-1:0]   held_address_q, held_address_d;
	logic [7:0]             held_data_q, held_data_d;
	logic                   is_write_q, is_write_d;
	logic [15:0]            wait_count_q, wait_count_d;
	logic                   error_flag_q, error_flag_d;
	logic [7:0]             received_byte_q, received_byte_d;

	logic [15:0] addr16;
	logic [7:0]  ctrl_byte;
	logic [2:0]  step_rel;
	elem_t       el_kind;
	logic [7:0]  el_byte;
	logic        do_adv;
	logic [15:0] wc_inc;
	logic        scl, sdo, drv, busy, done;

	// Element of the byte sequence at the current step
	always_comb begin
		addr16    = 16'(held_address_q);
		ctrl_byte = cfg.large_addressing ? CTRL_WR
			: (CTRL_WR | {4'b0000, addr16[10:8], 1'b0});
		step_rel  = (cfg.large_addressing && byte_step_q != 3'd0)
			? byte_step_q - 3'd1 : byte_step_q;
		el_kind   = EL_STOP;
		el_byte   = 8'h00;
		if (byte_step_q == 3'd0) begin
			el_kind = EL_SEND;
			el_byte = ctrl_byte;
		end else if (cfg.large_addressing && byte_step_q == 3'd1) begin
			el_kind = EL_SEND;
			el_byte = addr16[15:8];
		end else if (step_rel == 3'd1) begin
			el_kind = EL_SEND;
			el_byte = addr16[7:0];
		end else if (is_write_q) begin
			if (step_rel == 3'd2) begin
				el_kind = EL_SEND;
				el_byte = held_data_q;
			end
		end else if (step_rel == 3'd2) begin
			el_kind = EL_RESTART;
		end else if (step_rel == 3'd3) begin
			el_kind = EL_SEND;
			el_byte = CTRL_RD;
		end else if (step_rel == 3'd4) begin
			el_kind = EL_READ;
		end
	end

	assign wc_inc = (wait_count_q != 16'hFFFF) ? wait_count_q + 16'd1 : wait_count_q;

	// One bus phase tick
	always_comb begin
		phase_d         = phase_q;
		bit_count_d     = bit_count_q;
		shift_byte_d    = shift_byte_q;
		byte_step_d     = byte_step_q;
		held_address_d  = held_address_q;
		held_data_d     = held_data_q;
		is_write_d      = is_write_q;
		wait_count_d    = wait_count_q;
		error_flag_d    = error_flag_q;
		received_byte_d = received_byte_q;
		scl    = 1'b1;
		sdo    = 1'b1;
		drv    = 1'b1;
		busy   = 1'b1;
		done   = 1'b0;
		do_adv = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.command == CMD_READ || item.command == CMD_WRITE) begin
					held_address_d = item.address[ADDR_BITS-1:0];
					held_data_d    = item.write_data;
					is_write_d     = (item.command == CMD_WRITE);
					error_flag_d   = 1'b0;
					byte_step_d    = 3'd0;
					bit_count_d    = 3'd0;
					wait_count_d   = 16'd0;
					phase_d        = PH_ST2;
				end else begin
					busy = 1'b0;
				end
			end
			PH_ST2: begin
				sdo     = 1'b0;
				phase_d = PH_ST3;
			end
			PH_ST3: begin
				scl    = 1'b0;
				sdo    = 1'b0;
				do_adv = 1'b1;
			end
			PH_RS0: begin
				scl     = 1'b0;
				phase_d = PH_RS1;
			end
			PH_RS1: phase_d = PH_ST2;
			PH_TXL: begin
				scl     = 1'b0;
				sdo     = shift_byte_q[7];
				phase_d = PH_TXH;
			end
			PH_TXH: begin
				sdo          = shift_byte_q[7];
				shift_byte_d = {shift_byte_q[6:0], 1'b0};
				if (bit_count_q == 3'd7) begin
					wait_count_d = 16'd0;
					phase_d      = PH_AKL;
				end else begin
					bit_count_d = bit_count_q + 3'd1;
					phase_d     = PH_TXL;
				end
			end
			PH_AKL: begin
				scl     = 1'b0;
				drv     = 1'b0;
				phase_d = PH_AKH;
			end
			PH_AKH: begin
				drv = 1'b0;
				if (!item.sda_in) begin
					do_adv = 1'b1;
				end else begin
					wait_count_d = wc_inc;
					if (wc_inc >= {8'h00, cfg.ack_timeout}) begin
						error_flag_d = 1'b1;
						phase_d      = PH_SP1;
					end
				end
			end
			PH_RXL: begin
				scl     = 1'b0;
				drv     = 1'b0;
				phase_d = PH_RXH;
			end
			PH_RXH: begin
				drv          = 1'b0;
				shift_byte_d = {shift_byte_q[6:0], item.sda_in};
				if (bit_count_q == 3'd7) begin
					phase_d = PH_NKL;
				end else begin
					bit_count_d = bit_count_q + 3'd1;
					phase_d     = PH_RXL;
				end
			end
			PH_NKL: begin
				scl     = 1'b0;
				phase_d = PH_NKH;
			end
			PH_NKH: do_adv = 1'b1;
			PH_SP1: begin
				scl     = 1'b0;
				sdo     = 1'b0;
				phase_d = PH_SP2;
			end
			PH_SP2: begin
				sdo     = 1'b0;
				phase_d = PH_SP3;
			end
			PH_SP3: begin
				if (!error_flag_q && !is_write_q) received_byte_d = shift_byte_q;
				if (!error_flag_q && is_write_q && cfg.write_wait_ticks != 16'd0) begin
					wait_count_d = cfg.write_wait_ticks;
					phase_d      = PH_WAIT;
				end else begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			PH_WAIT: begin
				wait_count_d = (wait_count_q != 16'd0) ? wait_count_q - 16'd1 : wait_count_q;
				if (wait_count_d == 16'd0) begin
					done    = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				busy    = 1'b0;
			end
		endcase

		// Move on to the next element of the byte sequence
		if (do_adv) begin
			byte_step_d = (byte_step_q != 3'd7) ? byte_step_q + 3'd1 : byte_step_q;
			bit_count_d = 3'd0;
			case (el_kind)
				EL_SEND: begin
					shift_byte_d = el_byte;
					phase_d      = PH_TXL;
				end
				EL_RESTART: phase_d = PH_RS0;
				EL_READ: begin
					shift_byte_d = 8'h00;
					phase_d      = PH_RXL;
				end
				default: phase_d = PH_SP1;
			endcase
		end

		if (!drv) sdo = 1'b1;
		res.scl       = scl;
		res.sda_out   = sdo;
		res.sda_drive = drv;
		res.busy_res  = busy;
		res.done_res  = done;
		res.read_data = received_byte_d;
		res.ack_error = error_flag_d;
	end

	// Transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			bit_count_q     <= '0;
			shift_byte_q    <= '0;
			byte_step_q     <= '0;
			held_address_q  <= '0;
			held_data_q     <= '0;
			is_write_q      <= 1'b0;
			wait_count_q    <= '0;
			error_flag_q    <= 1'b0;
			received_byte_q <= '0;
		end else if (step_en) begin
			phase_q         <= phase_d;
			bit_count_q     <= bit_count_d;
			shift_byte_q    <= shift_byte_d;
			byte_step_q     <= byte_step_d;
			held_address_q  <= held_address_d;
			held_data_q     <= held_data_d;
			is_write_q      <= is_write_d;
			wait_count_q    <= wait_count_d;
			error_flag_q    <= error_flag_d;
			received_byte_q <= received_byte_d;
		end
	end

endmodule

### verif/i2c_eeprom_byte_access_master_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the serial EEPROM byte access master: drives bus-phase ticks,
// predicts the SCL/SDA levels and status of every tick, and compares results.
// Depends on i2cee_pkg and i2c_eeprom_byte_access_master_top.

module i2c_eeprom_byte_access_master_top_tb;
	import i2cee_pkg::*;

	// About 1850 ticks; even a gap and a stall on every tick stays far below
	localparam int CYCLE_LIMIT = 50_000;
	localparam int RANDOM_PHASES = 3;
	localparam int BUSY_TICKS_PER_PHASE = 80;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST2, PH_ST3, PH_RS0, PH_RS1, PH_TXL, PH_TXH, PH_AKL, PH_AKH,
		PH_RXL, PH_RXH, PH_NKL, PH_NKH, PH_SP1, PH_SP2, PH_SP3, PH_WAIT
	} bus_phase_e;

	typedef enum logic [1:0] {ELEM_SEND, ELEM_RESTART, ELEM_READ, ELEM_STOP} bus_elem_e;

	typedef enum logic [1:0] {RX_RANDOM, RX_ONES, RX_ZEROS} rx_fill_e;

	// Tracks the bus sequencer and holds the bus levels still due
	class bus_tick_board;
		bit         large_addr;
		bit [7:0]   ack_limit;
		bit [15:0]  wr_wait;
		bus_phase_e seq_phase;
		bit [2:0]   bit_idx;
		bit [7:0]   shreg;
		bit [2:0]   step;
		bit [15:0]  addr;
		bit [7:0]   wdata;
		bit         wr;
		bit [15:0]  wait_cnt;
		bit         err;
		bit [7:0]   rx_byte;
		result_t    bus_levels_due[$];
		int         mismatches;

		function new();
			large_addr = RST_LARGE_ADDR;
			ack_limit = RST_ACK_TIMEOUT;
			wr_wait = RST_WRITE_WAIT;
			seq_phase = PH_IDLE;
			bit_idx = '0;
			shreg = '0;
			step = '0;
			addr = '0;
			wdata = '0;
			wr = 1'b0;
			wait_cnt = '0;
			err = 1'b0;
			rx_byte = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_LARGE_ADDR:  large_addr = val[0];
				CFG_ACK_TIMEOUT: ack_limit = val[7:0];
				CFG_WRITE_WAIT:  wr_wait = val;
				default: ;
			endcase
		endfunction

		// Pick the next byte-level element of the transfer and enter it
		function void next_element();
			bit [7:0]  ctl;
			bit [7:0]  b;
			bit [2:0]  s;
			bus_elem_e k;
			ctl = large_addr ? CTRL_WR : (CTRL_WR | {4'b0, addr[10:8], 1'b0});
			s = step;
			b = '0;
			k = ELEM_STOP;
			if (s == 3'd0) begin
				k = ELEM_SEND;
				b = ctl;
			end else if (large_addr && s == 3'd1) begin
				k = ELEM_SEND;
				b = addr[15:8];
			end else begin
				if (large_addr)
					s = s - 3'd1;
				if (s == 3'd1) begin
					k = ELEM_SEND;
					b = addr[7:0];
				end else if (wr) begin
					if (s == 3'd2) begin
						k = ELEM_SEND;
						b = wdata;
					end
				end else if (s == 3'd2) begin
					k = ELEM_RESTART;
				end else if (s == 3'd3) begin
					k = ELEM_SEND;
					b = CTRL_RD;
				end else if (s == 3'd4) begin
					k = ELEM_READ;
				end
			end
			if (step < 3'd7)
				step = step + 3'd1;
			bit_idx = '0;
			case (k)
				ELEM_SEND: begin
					shreg = b;
					seq_phase = PH_TXL;
				end
				ELEM_RESTART: seq_phase = PH_RS0;
				ELEM_READ: begin
					shreg = '0;
					seq_phase = PH_RXL;
				end
				default: seq_phase = PH_SP1;
			endcase
		endfunction

		// One accepted tick: advance the sequencer and queue its bus levels
		function void predict_tick(item_t it);
			result_t r;
			r = '0;
			r.scl = 1'b1;
			r.sda_out = 1'b1;
			r.sda_drive = 1'b1;
			r.busy_res = 1'b1;
			case (seq_phase)
				PH_IDLE: begin
					if (it.command == CMD_READ || it.command == CMD_WRITE) begin
						addr = it.address;
						wdata = it.write_data;
						wr = (it.command == CMD_WRITE);
						err = 1'b0;
						step = '0;
						bit_idx = '0;
						wait_cnt = '0;
						seq_phase = PH_ST2;
					end else
						r.busy_res = 1'b0;
				end
				PH_ST2: begin
					r.sda_out = 1'b0;
					seq_phase = PH_ST3;
				end
				PH_ST3: begin
					r.scl = 1'b0;
					r.sda_out = 1'b0;
					next_element();
				end
				PH_RS0: begin
					r.scl = 1'b0;
					seq_phase = PH_RS1;
				end
				PH_RS1: seq_phase = PH_ST2;
				PH_TXL: begin
					r.scl = 1'b0;
					r.sda_out = shreg[7];
					seq_phase = PH_TXH;
				end
				PH_TXH: begin
					r.sda_out = shreg[7];
					shreg = {shreg[6:0], 1'b0};
					if (bit_idx == 3'd7) begin
						wait_cnt = '0;
						seq_phase = PH_AKL;
					end else begin
						bit_idx = bit_idx + 3'd1;
						seq_phase = PH_TXL;
					end
				end
				PH_AKL: begin
					r.scl = 1'b0;
					r.sda_drive = 1'b0;
					seq_phase = PH_AKH;
				end
				PH_AKH: begin
					r.sda_drive = 1'b0;
					if (!it.sda_in)
						next_element();
					else begin
						// ack held high: count toward the abort limit
						if (wait_cnt != 16'hFFFF)
							wait_cnt = wait_cnt + 16'd1;
						if (wait_cnt >= ack_limit) begin
							err = 1'b1;
							seq_phase = PH_SP1;
						end
					end
				end
				PH_RXL: begin
					r.scl = 1'b0;
					r.sda_drive = 1'b0;
					seq_phase = PH_RXH;
				end
				PH_RXH: begin
					r.sda_drive = 1'b0;
					shreg = {shreg[6:0], it.sda_in};
					if (bit_idx == 3'd7)
						seq_phase = PH_NKL;
					else begin
						bit_idx = bit_idx + 3'd1;
						seq_phase = PH_RXL;
					end
				end
				PH_NKL: begin
					r.scl = 1'b0;
					seq_phase = PH_NKH;
				end
				PH_NKH: next_element();
				PH_SP1: begin
					r.scl = 1'b0;
					r.sda_out = 1'b0;
					seq_phase = PH_SP2;
				end
				PH_SP2: begin
					r.sda_out = 1'b0;
					seq_phase = PH_SP3;
				end
				PH_SP3: begin
					if (!err && !wr)
						rx_byte = shreg;
					if (!err && wr && wr_wait != 16'd0) begin
						wait_cnt = wr_wait;
						seq_phase = PH_WAIT;
					end else begin
						r.done_res = 1'b1;
						seq_phase = PH_IDLE;
					end
				end
				PH_WAIT: begin
					if (wait_cnt != 16'd0)
						wait_cnt = wait_cnt - 16'd1;
					if (wait_cnt == 16'd0) begin
						r.done_res = 1'b1;
						seq_phase = PH_IDLE;
					end
				end
				default: begin
					seq_phase = PH_IDLE;
					r.busy_res = 1'b0;
				end
			endcase
			// released SDA reads back as high
			if (!r.sda_drive)
				r.sda_out = 1'b1;
			r.read_data = rx_byte;
			r.ack_error = err;
			bus_levels_due.push_back(r);
		endfunction

		function void check_field(string fld, int unsigned exp_v, int unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", fld, exp_v, act_v);
				mismatches++;
			end
		endfunction

		function void check_tick(result_t got);
			result_t exp_r;
			if (bus_levels_due.size() == 0) begin
				$error("result item with no tick outstanding");
				mismatches++;
				return;
			end
			exp_r = bus_levels_due.pop_front();
			check_field("scl", 32'(exp_r.scl), 32'(got.scl));
			check_field("sda_out", 32'(exp_r.sda_out), 32'(got.sda_out));
			check_field("sda_drive", 32'(exp_r.sda_drive), 32'(got.sda_drive));
			check_field("busy_res", 32'(exp_r.busy_res), 32'(got.busy_res));
			check_field("done_res", 32'(exp_r.done_res), 32'(got.done_res));
			check_field("read_data", 32'(exp_r.read_data), 32'(got.read_data));
			check_field("ack_error", 32'(exp_r.ack_error), 32'(got.ack_error));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_idx = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	bus_tick_board sb;
	bit            calm = 1'b0;
	bit            abort_armed = 1'b0;
	int            noise_pct = 0;
	rx_fill_e      rx_fill = RX_RANDOM;
	int            cycle_count = 0;

	i2c_eeprom_byte_access_master_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stalls, check every accepted item
	always @(posedge clk) begin : result_sink
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.scl = m_axis_tdata[0];
			got.sda_out = m_axis_tdata[1];
			got.sda_drive = m_axis_tdata[2];
			got.busy_res = m_axis_tdata[3];
			got.done_res = m_axis_tdata[4];
			got.read_data = m_axis_tdata[12:5];
			got.ack_error = m_axis_tdata[13];
			sb.check_tick(got);
		end
		m_axis_tready <= calm || ($urandom_range(99) >= 12);
	end

	// Next tick, shaped by the phase the sequencer is in
	function automatic item_t make_tick();
		item_t it;
		it.address = 16'($urandom_range(16'hFFFF));
		it.write_data = 8'($urandom_range(8'hFF));
		it.sda_in = 1'($urandom_range(1));
		it.command = 2'($urandom_range(3));
		if (sb.seq_phase == PH_IDLE) begin
			case ($urandom_range(9))
				0: it.command = CMD_NONE;
				1: it.command = CMD_UNUSED;
				default: it.command = $urandom_range(1) ? CMD_WRITE : CMD_READ;
			endcase
			abort_armed = ($urandom_range(9) == 0);
		end
		case (sb.seq_phase)
			PH_AKH: it.sda_in = abort_armed || ($urandom_range(99) < noise_pct);
			PH_RXH: begin
				if (rx_fill == RX_ONES)
					it.sda_in = 1'b1;
				else if (rx_fill == RX_ZEROS)
					it.sda_in = 1'b0;
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic send_tick(input item_t it);
		if (!calm && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, it.sda_in, it.write_data, it.address, it.command};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.predict_tick(it);
	endtask

	// One command tick, then ticks until the sequencer is idle again
	task automatic run_request(input logic [1:0] cmd, input logic [15:0] addr,
			input logic [7:0] data, input bit abort, input rx_fill_e fill);
		item_t it;
		it = make_tick();
		it.command = cmd;
		it.address = addr;
		it.write_data = data;
		abort_armed = abort;
		rx_fill = fill;
		send_tick(it);
		while (sb.seq_phase != PH_IDLE) send_tick(make_tick());
	endtask

	// Wait for all results to come out of the block's two register stages
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.bus_levels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic apply_cfg(input logic large_sel, input logic [7:0] ack_lim,
			input logic [15:0] ww);
		write_reg(CFG_LARGE_ADDR, {15'b0, large_sel});
		write_reg(CFG_ACK_TIMEOUT, {8'b0, ack_lim});
		write_reg(CFG_WRITE_WAIT, ww);
	endtask

	initial begin
		item_t      it;
		int         busy_ticks;
		int         p;
		logic       rnd_large;
		logic [7:0] rnd_ack;
		logic [15:0] rnd_wait;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, small addressing, long write wait
		noise_pct = 0;
		run_request(CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b0, RX_RANDOM);
		run_request(CMD_NONE, 16'hFFFF, 8'hFF, 1'b0, RX_RANDOM);
		run_request(CMD_WRITE, 16'h0000, 8'h00, 1'b0, RX_RANDOM);
		run_request(CMD_READ, 16'hFFFF, 8'h00, 1'b0, RX_ONES);
		run_request(CMD_READ, 16'h0000, 8'hFF, 1'b0, RX_ZEROS);
		settle();

		// Two address bytes, zero ack timeout, no write wait
		apply_cfg(1'b1, 8'd0, 16'd0);
		run_request(CMD_WRITE, 16'hFFFF, 8'hA5, 1'b0, RX_RANDOM);
		run_request(CMD_READ, 16'h00FF, 8'h00, 1'b0, RX_ONES);
		run_request(CMD_READ, 16'hABCD, 8'h00, 1'b1, RX_RANDOM);
		run_request(CMD_WRITE, 16'h8001, 8'h5A, 1'b1, RX_RANDOM);
		settle();

		// Longest ack timeout, short write wait, top address bits in control byte
		apply_cfg(1'b0, 8'd255, 16'd3);
		run_request(CMD_WRITE, 16'hFFFF, 8'hFF, 1'b0, RX_RANDOM);
		run_request(CMD_READ, 16'h0345, 8'h00, 1'b0, RX_RANDOM);
		settle();

		apply_cfg(1'b1, 8'd1, 16'd1);
		run_request(CMD_WRITE, 16'h1234, 8'h81, 1'b0, RX_RANDOM);
		run_request(CMD_READ, 16'h4321, 8'h00, 1'b0, RX_ZEROS);
		settle();

		// Random transfers, new settings per phase, ack noise and aborts
		noise_pct = 8;
		rx_fill = RX_RANDOM;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			rnd_large = 1'($urandom_range(1));
			case ($urandom_range(9))
				0, 1: rnd_ack = 8'd1;
				2: rnd_ack = 8'd255;
				default: rnd_ack = 8'($urandom_range(6, 2));
			endcase
			rnd_wait = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(24, 1));
			apply_cfg(rnd_large, rnd_ack, rnd_wait);
			calm = (p == 2);
			busy_ticks = 0;
			while (busy_ticks < BUSY_TICKS_PER_PHASE) begin
				it = make_tick();
				if (sb.seq_phase != PH_IDLE || it.command == CMD_READ
						|| it.command == CMD_WRITE)
					busy_ticks++;
				send_tick(it);
			end
			while (sb.seq_phase != PH_IDLE) send_tick(make_tick());
			settle();
		end

		if (sb.mismatches == 0 && sb.bus_levels_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_core.sv
hw/rtl/i2c_eeprom_byte_access_master_top.sv
verif/i2c_eeprom_byte_access_master_top_tb.sv
